// ===== rtl/epoch_seconds_to_civil_date_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to civil date block
// Shared implication and never-true checks, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_ASSERT_SVH

// The consequent must hold whenever the antecedent holds.
`define ESCD_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true.
`define ESCD_ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("never check failed");

`endif

// ===== rtl/escd_pkg.sv =====
// ----------------------------------------------------------------------------
// escd_pkg
// Constants for the epoch seconds to civil date converter: reciprocals for
// constant division and the cumulative month table.
// ----------------------------------------------------------------------------
package escd_pkg;

    // Seconds per day split as 128 * 675; reciprocal of 675 with shift 35.
    localparam logic [25:0] RecipDay   = 26'd50903317;
    localparam int          ShDay      = 35;
    localparam logic [16:0] SecsPerDay = 17'd86400;

    // Reciprocals for hour, minute and weekday extraction.
    localparam logic [17:0] RecipHour  = 18'd149131;
    localparam int          ShHour     = 29;
    localparam logic [12:0] RecipMin   = 13'd4370;
    localparam int          ShMin      = 18;
    localparam logic [16:0] RecipWeek  = 17'd74899;
    localparam int          ShWeek     = 19;

    // Four-year blocks counted from 1968-01-01.
    localparam logic [16:0] RecipBlock = 17'd91868;
    localparam int          ShBlock    = 27;
    localparam logic [10:0] DaysBlock  = 11'd1461;
    localparam logic [15:0] Off1968    = 16'd731;
    // Day index of 2100-03-01 from 1968-01-01; 2100 has no leap day.
    localparam logic [15:0] Mar2100    = 16'd48272;
    localparam logic [5:0]  Block2100  = 6'd33;

    typedef logic [8:0] mstart_t [12];

    // Days before the first of each month in a common year.
    localparam mstart_t MonthStart = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                       9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

endpackage

// ===== rtl/epoch_seconds_to_civil_date.sv =====
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is not taken, so a stall loses or repeats nothing.
// Divisions by constants are reciprocal multiplies.
// Reset: rst_n clears all stage valid bits asynchronously; data needs none.
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date
// Converts unsigned Unix seconds into UTC time of day, weekday, year,
// day of year, month and day of month in a nine stage pipeline.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_civil_date_assert.svh"

module epoch_seconds_to_civil_date
    import escd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
    // [45:41] day_of_month, [47:46] zero
    output logic [47:0] m_axis_tdata
);

    logic [9:1] v_reg;
    logic       ce;

    // Stage data registers.
    logic [31:0] t1_reg, t2_reg;
    logic [50:0] pd2_reg;
    logic [15:0] days3_reg;
    logic [16:0] tod3_reg, tod4_reg;
    logic [34:0] ph4_reg;
    logic [33:0] pw4_reg;
    logic [15:0] w4_reg, d4_reg, d5_reg, d6_reg;
    logic        adj4_reg, adj5_reg, adj6_reg, adj7_reg;
    logic [4:0]  hour5_reg, hour6_reg, hour7_reg, hour8_reg;
    logic [11:0] m5_reg, m6_reg;
    logic [2:0]  wd5_reg, wd6_reg, wd7_reg, wd8_reg;
    logic [32:0] pb5_reg;
    logic [5:0]  min6_reg, min7_reg, min8_reg;
    logic [5:0]  q6_reg, q7_reg;
    logic [10:0] r7_reg;
    logic [5:0]  sec7_reg, sec8_reg;
    logic [7:0]  yr8_reg;
    logic [8:0]  yday8_reg;
    logic        leap8_reg;
    logic [7:0]  yr_out_reg;
    logic [8:0]  yday_out_reg;
    logic [3:0]  mon_out_reg;
    logic [4:0]  mday_out_reg;
    logic [5:0]  sec_out_reg, min_out_reg;
    logic [4:0]  hour_out_reg;
    logic [2:0]  wd_out_reg;

    // The pipeline advances whenever the last stage is empty or drained.
    assign ce            = !v_reg[9] || m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = v_reg[9];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[8:1], s_axis_tvalid};
        end
    end

    // Combinational helpers for stages that need more than a register copy.
    logic [15:0] days_c, d_raw_c;
    logic [4:0]  hour_c;
    logic [2:0]  w_q_c, wd_c;
    logic [5:0]  min_c, q_c;
    logic [1:0]  y_c;
    logic [10:0] ystart_c, r_c;
    logic [8:0]  yday_c, dd_c;
    logic        is2100_c;
    logic [3:0]  mon_c;
    logic [4:0]  mday_c;
    logic [15:0] wq_c;

    always_comb
    begin
        days_c   = pd2_reg[50:ShDay];
        d_raw_c  = days3_reg + Off1968;
        hour_c   = ph4_reg[ShHour +: 5];
        wq_c     = 16'(pw4_reg[33:ShWeek]);
        w_q_c    = 3'(w4_reg - 16'(wq_c * 16'd7));
        wd_c     = w_q_c;
        q_c      = pb5_reg[32:ShBlock];
        min_c    = 6'(25'(m5_reg * RecipMin) >> ShMin);
        // Year within the four-year block; the first year is the leap year.
        if (r7_reg < 11'd366)
        begin
            y_c = 2'd0; ystart_c = 11'd0;
        end
        else if (r7_reg < 11'd731)
        begin
            y_c = 2'd1; ystart_c = 11'd366;
        end
        else if (r7_reg < 11'd1096)
        begin
            y_c = 2'd2; ystart_c = 11'd731;
        end
        else
        begin
            y_c = 2'd3; ystart_c = 11'd1096;
        end
        r_c      = r7_reg - ystart_c;
        is2100_c = (q7_reg == Block2100) && (y_c == 2'd0);
        yday_c   = r_c[8:0] - {8'd0, adj7_reg && is2100_c};
        // Month search with the leap day folded out.
        dd_c   = yday8_reg;
        mday_c = 5'd1;
        if (leap8_reg && yday8_reg > 9'd58)
        begin
            if (yday8_reg == 9'd59)
            begin
                mday_c = 5'd2;
            end
            dd_c = yday8_reg - 9'd1;
        end
        mon_c = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (MonthStart[i] <= dd_c)
            begin
                mon_c = 4'(i);
            end
        end
        mday_c = mday_c + 5'(dd_c - MonthStart[mon_c]);
    end

    // Pipeline stages.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // Stage 1: capture the input.
            t1_reg <= s_axis_tdata;
            // Stage 2: days = (t / 128) / 675 by reciprocal.
            t2_reg  <= t1_reg;
            pd2_reg <= 51'(t1_reg[31:7] * RecipDay);
            // Stage 3: time of day remainder.
            days3_reg <= days_c;
            tod3_reg  <= 17'(t2_reg - 32'(days_c * SecsPerDay));
            // Stage 4: hour and weekday products, shifted day count.
            tod4_reg <= tod3_reg;
            ph4_reg  <= 35'(tod3_reg * RecipHour);
            w4_reg   <= days3_reg + 16'd4;
            pw4_reg  <= 34'((days3_reg + 16'd4) * RecipWeek);
            adj4_reg <= (d_raw_c >= Mar2100);
            d4_reg   <= d_raw_c + {15'd0, d_raw_c >= Mar2100};
            // Stage 5: hour, weekday, four-year block product.
            hour5_reg <= hour_c;
            m5_reg    <= 12'(tod4_reg - 17'(hour_c * 12'd3600));
            wd5_reg   <= wd_c;
            pb5_reg   <= 33'(d4_reg * RecipBlock);
            d5_reg    <= d4_reg;
            adj5_reg  <= adj4_reg;
            // Stage 6: minute, block index.
            hour6_reg <= hour5_reg;
            wd6_reg   <= wd5_reg;
            min6_reg  <= min_c;
            m6_reg    <= m5_reg;
            q6_reg    <= q_c;
            d6_reg    <= d5_reg;
            adj6_reg  <= adj5_reg;
            // Stage 7: second, day within block.
            hour7_reg <= hour6_reg;
            wd7_reg   <= wd6_reg;
            min7_reg  <= min6_reg;
            sec7_reg  <= 6'(m6_reg - 12'(min6_reg * 12'd60));
            q7_reg    <= q6_reg;
            r7_reg    <= 11'(d6_reg - 16'(q6_reg * DaysBlock));
            adj7_reg  <= adj6_reg;
            // Stage 8: year and day of year.
            hour8_reg <= hour7_reg;
            wd8_reg   <= wd7_reg;
            min8_reg  <= min7_reg;
            sec8_reg  <= sec7_reg;
            yr8_reg   <= 8'd68 + {q7_reg, 2'b00} + {6'd0, y_c};
            yday8_reg <= yday_c;
            leap8_reg <= (y_c == 2'd0) && !is2100_c;
            // Output register: month and day of month.
            sec_out_reg  <= sec8_reg;
            min_out_reg  <= min8_reg;
            hour_out_reg <= hour8_reg;
            wd_out_reg   <= wd8_reg;
            yr_out_reg   <= yr8_reg;
            yday_out_reg <= yday8_reg;
            mon_out_reg  <= mon_c;
            mday_out_reg <= mday_c;
        end
    end

    assign m_axis_tdata = {2'b00, mday_out_reg, mon_out_reg, yday_out_reg, yr_out_reg,
                           wd_out_reg, hour_out_reg, min_out_reg, sec_out_reg};

    // Range conditions on the output beat.
    logic time_ok_c, date_ok_c;

    assign time_ok_c = (m_axis_tdata[5:0] < 6'd60) && (m_axis_tdata[11:6] < 6'd60) &&
                       (m_axis_tdata[16:12] < 5'd24);
    assign date_ok_c = (m_axis_tdata[40:37] < 4'd12) && (m_axis_tdata[45:41] != 5'd0) &&
                       (m_axis_tdata[36:28] < 9'd366);

    // Result fields stay inside their calendar ranges.
    `ESCD_ASSERT_IMPLY(a_time_range, clk, rst_n, m_axis_tvalid, time_ok_c)
    `ESCD_ASSERT_IMPLY(a_date_range, clk, rst_n, m_axis_tvalid, date_ok_c)
    `ESCD_ASSERT_NEVER(a_weekday, clk, rst_n, m_axis_tvalid && (m_axis_tdata[19:17] == 3'd7))

endmodule

// ===== sim/civil_date_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// civil_date_checker
// Watches both stream channels of the converter, computes the expected UTC
// calendar fields for every accepted input beat and compares each output
// beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module civil_date_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [1:0] pad;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [8:0] day_of_year;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } civil_date_t;

    civil_date_t expected_dates[$];

    function automatic bit is_leap(int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Year-by-year reduction of the day count, then a month table search.
    function automatic civil_date_t to_civil(logic [31:0] secs);
        civil_date_t d;
        int unsigned tod;
        int unsigned days;
        int unsigned yr;
        int unsigned len;
        int unsigned mday;
        int unsigned mon;
        int unsigned cum[12];
        cum = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        tod  = secs % 86400;
        days = secs / 86400;
        d = '0;
        d.second  = 6'(tod % 60);
        d.minute  = 6'((tod / 60) % 60);
        d.hour    = 5'(tod / 3600);
        d.weekday = 3'((4 + days) % 7);
        yr = 1970;
        len = is_leap(yr) ? 366 : 365;
        while (days >= len)
        begin
            days -= len;
            yr++;
            len = is_leap(yr) ? 366 : 365;
        end
        d.day_of_year = 9'(days);
        mday = 1;
        // In leap years the 29th of February borrows from the day after it.
        if (is_leap(yr) && days > 58)
        begin
            if (days == 59)
                mday = 2;
            days -= 1;
        end
        mon = 11;
        while (mon > 0 && cum[mon] > days)
            mon--;
        mday += days - cum[mon];
        d.years_since_1900 = 8'(yr - 1900);
        d.month = 4'(mon);
        d.day_of_month = 5'(mday);
        return d;
    endfunction

    assign pending_count = expected_dates.size();

    always @(posedge clk or negedge rst_n)
    begin
        civil_date_t got;
        civil_date_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_dates.push_back(to_civil(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_dates.size() == 0)
                begin
                    $error("output beat with no prediction pending: %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got != want)
                    begin
                        fail_count <= fail_count + 1;
                        if (got.second != want.second)
                            $error("second expected %0d actual %0d", want.second, got.second);
                        if (got.minute != want.minute)
                            $error("minute expected %0d actual %0d", want.minute, got.minute);
                        if (got.hour != want.hour)
                            $error("hour expected %0d actual %0d", want.hour, got.hour);
                        if (got.weekday != want.weekday)
                            $error("weekday expected %0d actual %0d",
                                   want.weekday, got.weekday);
                        if (got.years_since_1900 != want.years_since_1900)
                            $error("years_since_1900 expected %0d actual %0d",
                                   want.years_since_1900, got.years_since_1900);
                        if (got.day_of_year != want.day_of_year)
                            $error("day_of_year expected %0d actual %0d",
                                   want.day_of_year, got.day_of_year);
                        if (got.month != want.month)
                            $error("month expected %0d actual %0d", want.month, got.month);
                        if (got.day_of_month != want.day_of_month)
                            $error("day_of_month expected %0d actual %0d",
                                   want.day_of_month, got.day_of_month);
                        if (got.pad != want.pad)
                            $error("pad expected %0d actual %0d", want.pad, got.pad);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives Unix second counts into the civil date converter: directed calendar
// corners first, then random times under varying handshake pressure, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;

    localparam int RandomItems = 800;
    localparam int Drain = 40;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    bit          hold_off_req;
    bit          hold_off_done;

    epoch_seconds_to_civil_date u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    civil_date_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off once it is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (hold_off_req && !hold_off_done)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= 60;
            hold_off_done <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one beat, idling at random beforehand, and waits for acceptance.
    task automatic send_seconds(input logic [31:0] secs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Picks a random time, often near a day, year or leap-day boundary.
    function automatic logic [31:0] random_seconds();
        logic [31:0] days;
        case ($urandom_range(3))
            0: return $urandom;
            1:
            begin
                days = $urandom_range(49710);
                return days * 86400 + $urandom_range(86399);
            end
            default:
            begin
                // Around 28 Feb to 2 Mar or 31 Dec to 1 Jan of a random year.
                days = 365 * $urandom_range(136) + $urandom_range(33) + 50 +
                       ($urandom_range(1) ? 0 : 300);
                return (days * 86400 + $urandom_range(86399)) & 32'hFFFFFFFF;
            end
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        int phase;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Epoch start, end of first day, largest input, leap days, century years.
        directed = '{32'd0, 32'd86399, 32'd86400, 32'hFFFFFFFF, 32'hFFFFFFFE,
                     32'd68169600, 32'd68255999, 32'd68256000, 32'd951782400,
                     32'd951868800, 32'd951868799, 32'd978220800, 32'd978307199,
                     32'd4107542400, 32'd4107542399, 32'd4102444800, 32'd31535999,
                     32'd31536000, 32'd2147483647, 32'd2147483648, 32'h55555555,
                     32'hAAAAAAAA, 32'd1709164800};
        foreach (directed[i])
            send_seconds(directed[i]);

        for (int n = 0; n < RandomItems; n++)
        begin
            phase = n / 160;
            send_idle_pct  = (phase == 1) ? 59 : (phase == 3) ? 25 : 0;
            recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 25 : 0;
            // Long receiver hold-off so the pipeline fills and backs up.
            if (n == 720)
                hold_off_req <= 1'b1;
            send_seconds(random_seconds());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (Drain) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/escd_pkg.sv
rtl/epoch_seconds_to_civil_date.sv
sim/civil_date_checker.sv
sim/tb.sv
